>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each one samples on clk and is disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// Stereo tremolo package
// Widths, fixed-point constants, register indexes and the operation codes of
// the serial multiplier sequence.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 32;
  localparam int TABLE_W    = 10;
  localparam int STEP_W     = 31;
  localparam int DEPTH_W    = 16;
  localparam int CC_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int TDATA_W    = 2 * SAMPLE_W;

  // Q16 working values (t, t2, polynomial terms, s, lfo) fit in 17 bits
  localparam int VAL_W = 17;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

  // Sine polynomial coefficients in Q16
  localparam logic [VAL_W-1:0] COEF1 = 17'd102944;
  localparam logic [VAL_W-1:0] COEF3 = 17'd42334;
  localparam logic [VAL_W-1:0] COEF5 = 17'd4926;

  // Unity in Q1.16 and Q1.15
  localparam logic [VAL_W-1:0]   ONE_Q16 = 17'd65536;
  localparam logic [DEPTH_W-1:0] ONE_Q15 = 16'd32768;

  // Digit-serial multiplier geometry: signed multiplicand, unsigned
  // multiplier consumed one digit per cycle, least significant first.
  localparam int DIGIT_W   = 4;
  localparam int MA_W      = VAL_W + 1;
  localparam int MB_W      = 20;
  localparam int MUL_STEPS = MB_W / DIGIT_W;
  localparam int STEP_CNT_W = $clog2(MUL_STEPS);
  localparam int ACC_W     = MA_W + DIGIT_W + 1;
  localparam int PROD_W    = ACC_W + MB_W;

  // Multiply operations, in the order they run for one frame
  typedef enum logic [2:0] {
    OP_TT,     // t * t              -> t2
    OP_T2C5,   // t2 * C5            -> inner = C3 - rnd
    OP_T2IN,   // t2 * inner         -> mid = C1 - rnd
    OP_TMID,   // t * mid            -> s, clamped to one
    OP_SS,     // s * s              -> lfo
    OP_DLFO,   // depth * lfo        -> gain = 1 - rnd
    OP_LEFT,   // left * gain        -> left result
    OP_RIGHT   // right * gain       -> right result
  } op_t;

endpackage

>>> hw/rtl/stereo_tremolo.sv
// ----------------------------------------------------------------------------
// Stereo tremolo
// Raised-cosine LFO tremolo on one stereo frame per item, built around one
// shared digit-serial multiplier that runs the sine polynomial, the depth
// scaling and the per-channel gain in sequence.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                          | Handshake
//  --------+-----------+----------------------------------+-------------------
//  in_     | input     | tdata: left_in, right_in         | tvalid / tready
//  out_    | output    | tdata: left_out, right_out       | tvalid / tready
//  cfg_    | input     | addr: register, wdata: value     | we, no wait
//
//  One item is processed at a time. Each multiply has a load step and then
//  the digit steps of the 18x4 serial multiplier; a disabled item skips the
//  multiplies, and a mono item skips the right-channel multiply.
//  A finished item waits in the output register; the next item is accepted
//  while it waits, and work stalls only when a new result finds it still full.
//  Reset (rst_n, synchronous) resets phase, config and handshake state.

module stereo_tremolo (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [stt_pkg::TDATA_W-1:0]      in_tdata,   // [15:0] left_in, [31:16] right_in
  // Result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [stt_pkg::TDATA_W-1:0]      out_tdata,  // [15:0] left_out, [31:16] right_out
  // Configuration writes
  input  logic                             cfg_we,
  input  logic [stt_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [stt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import stt_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_NEXT,
    S_OUT
  } state_t;

  // Configuration registers
  logic                en_r;
  logic [STEP_W-1:0]   step_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [CC_W-1:0]     cc_r;

  // Control state
  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [STEP_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PHASE_W-1:0]      lfo_phase_r, lfo_phase_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Datapath registers
  logic signed [MA_W-1:0]  a_r, a_nxt;
  logic [MB_W-1:0]         b_r, b_nxt;
  logic signed [ACC_W-1:0] hi_r, hi_nxt;
  logic [VAL_W-1:0]        t_r, t_nxt;
  logic [VAL_W-1:0]        t2_r, t2_nxt;
  logic [VAL_W-1:0]        tmp_r, tmp_nxt;
  logic [DEPTH_W-1:0]      gain_r, gain_nxt;
  logic [SAMPLE_W-1:0]     left_r, left_nxt;
  logic [SAMPLE_W-1:0]     right_r, right_nxt;
  logic [SAMPLE_W-1:0]     out_left_r, out_left_nxt;
  logic [SAMPLE_W-1:0]     out_right_r, out_right_nxt;

  // Combinational helpers
  logic                    in_acc;
  logic                    out_free;
  logic [TABLE_W-1:0]      k_idx;
  logic [TABLE_W-1:0]      u_idx;
  logic [VAL_W-1:0]        t_new;
  logic signed [ACC_W-1:0] a_ext;
  logic signed [ACC_W-1:0] d_ext;
  logic signed [ACC_W-1:0] pp;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [PROD_W-1:0] prod;
  logic [VAL_W:0]          r16;
  logic signed [VAL_W:0]   q15;
  logic [SAMPLE_W-1:0]     sat;
  logic [VAL_W:0]          diff;
  logic [DEPTH_W-1:0]      depth_eff;
  logic                    stereo;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_right_r, out_left_r};
  assign out_free   = !out_valid_r || out_tready;

  // Table index from the top phase bits, folded to the first half cycle
  assign k_idx = lfo_phase_r[PHASE_W-1 -: TABLE_W];
  always_comb begin
    if (k_idx <= TABLE_W'(1 << (TABLE_W - 1))) begin
      u_idx = k_idx;
    end else begin
      u_idx = TABLE_W'(0) - k_idx;
    end
  end
  assign t_new = {u_idx, (VAL_W - TABLE_W)'(0)};

  // One digit step of the multiplier: add multiplicand times digit
  assign a_ext   = ACC_W'(a_r);
  assign d_ext   = $signed({(ACC_W - DIGIT_W)'(0), b_r[DIGIT_W-1:0]});
  assign pp      = a_ext * d_ext;
  assign acc_sum = hi_r + pp;

  // Finished product and its two rounding forms
  assign prod = $signed({hi_r, b_r});
  assign r16  = prod[VAL_W+16:16] + {(VAL_W)'(0), prod[15]};
  assign q15  = $signed(prod[VAL_W+15:15]) + $signed({(VAL_W)'(0), prod[14]});

  // Saturate the rounded channel product to the sample range
  always_comb begin
    if (q15 > $signed((VAL_W + 1)'((1 << (SAMPLE_W - 1)) - 1))) begin
      sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (q15 < -$signed((VAL_W + 1)'(1 << (SAMPLE_W - 1)))) begin
      sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      sat = q15[SAMPLE_W-1:0];
    end
  end

  assign depth_eff = (depth_r > ONE_Q15) ? ONE_Q15 : depth_r;
  assign stereo    = cc_r[1];

  // Sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    lfo_phase_nxt = lfo_phase_r;
    out_valid_nxt = out_valid_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    hi_nxt        = hi_r;
    t_nxt         = t_r;
    t2_nxt        = t2_r;
    tmp_nxt       = tmp_r;
    gain_nxt      = gain_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    diff          = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          left_nxt  = in_tdata[SAMPLE_W-1:0];
          right_nxt = in_tdata[TDATA_W-1:SAMPLE_W];
          if (en_r) begin
            // Start the polynomial with t * t; the phase advances now
            t_nxt         = t_new;
            a_nxt         = {1'b0, t_new};
            b_nxt         = MB_W'(t_new);
            hi_nxt        = '0;
            cnt_nxt       = '0;
            op_nxt        = OP_TT;
            lfo_phase_nxt = lfo_phase_r + PHASE_W'(step_r);
            state_nxt     = S_MUL;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end

      S_MUL: begin
        hi_nxt = acc_sum >>> DIGIT_W;
        b_nxt  = {acc_sum[DIGIT_W-1:0], b_r[MB_W-1:DIGIT_W]};
        if (cnt_r == STEP_CNT_W'(MUL_STEPS - 1)) begin
          state_nxt = S_NEXT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_NEXT: begin
        // Take the finished product and set up the following multiply
        hi_nxt    = '0;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
        unique case (op_r)
          OP_TT: begin
            t2_nxt = r16[VAL_W-1:0];
            a_nxt  = $signed({1'b0, COEF5});
            b_nxt  = MB_W'(r16[VAL_W-1:0]);
            op_nxt = OP_T2C5;
          end
          OP_T2C5: begin
            diff    = {1'b0, COEF3} - r16;
            tmp_nxt = diff[VAL_W-1:0];
            a_nxt   = $signed({1'b0, diff[VAL_W-1:0]});
            b_nxt   = MB_W'(t2_r);
            op_nxt  = OP_T2IN;
          end
          OP_T2IN: begin
            diff    = {1'b0, COEF1} - r16;
            tmp_nxt = diff[VAL_W-1:0];
            a_nxt   = $signed({1'b0, diff[VAL_W-1:0]});
            b_nxt   = MB_W'(t_r);
            op_nxt  = OP_TMID;
          end
          OP_TMID: begin
            // s is clamped to one before squaring
            if (r16 > {1'b0, ONE_Q16}) begin
              tmp_nxt = ONE_Q16;
            end else begin
              tmp_nxt = r16[VAL_W-1:0];
            end
            a_nxt  = $signed({1'b0, tmp_nxt});
            b_nxt  = MB_W'(tmp_nxt);
            op_nxt = OP_SS;
          end
          OP_SS: begin
            tmp_nxt = r16[VAL_W-1:0];
            a_nxt   = $signed({1'b0, r16[VAL_W-1:0]});
            b_nxt   = MB_W'(depth_eff);
            op_nxt  = OP_DLFO;
          end
          OP_DLFO: begin
            diff     = (VAL_W + 1)'(ONE_Q15) - r16;
            gain_nxt = diff[DEPTH_W-1:0];
            a_nxt    = MA_W'($signed(left_r));
            b_nxt    = MB_W'(diff[DEPTH_W-1:0]);
            op_nxt   = OP_LEFT;
          end
          OP_LEFT: begin
            left_nxt = sat;
            if (stereo) begin
              a_nxt  = MA_W'($signed(right_r));
              b_nxt  = MB_W'(gain_r);
              op_nxt = OP_RIGHT;
            end else begin
              state_nxt = S_OUT;
            end
          end
          OP_RIGHT: begin
            right_nxt = sat;
            state_nxt = S_OUT;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end

      S_OUT: begin
        // Hand the frame to the output register once it is free
        if (out_free) begin
          out_left_nxt  = left_r;
          out_right_nxt = right_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TT;
      cnt_r       <= '0;
      lfo_phase_r <= '0;
      out_valid_r <= 1'b0;
      en_r        <= 1'b0;
      step_r      <= '0;
      depth_r     <= '0;
      cc_r        <= CC_W'(2);
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      lfo_phase_r <= lfo_phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_ENABLE:        en_r    <= cfg_wdata[0];
          REG_PHASE_STEP:    step_r  <= cfg_wdata[STEP_W-1:0];
          REG_DEPTH:         depth_r <= cfg_wdata[DEPTH_W-1:0];
          REG_CHANNEL_COUNT: cc_r    <= cfg_wdata[CC_W-1:0];
          default: ;
        endcase
      end
    end
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    hi_r        <= hi_nxt;
    t_r         <= t_nxt;
    t2_r        <= t2_nxt;
    tmp_r       <= tmp_nxt;
    gain_r      <= gain_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  // The phase may only move on an item taken while enabled.
  `ASSERT_NEXT(a_phase_hold, !(in_acc && en_r), lfo_phase_r == $past(lfo_phase_r), "phase moved")
  // Only one item is in work at a time.
  `ASSERT_NEXT(a_one_item, in_acc, !in_tready, "input taken while an item is in work")
  // The digit counter stays within the multiplier length.
  `ASSERT_NOW(a_cnt_range, state_r == S_MUL, cnt_r < STEP_CNT_W'(MUL_STEPS), "counter overran")

endmodule

>>> sim/stereo_tremolo_tb.sv
// ----------------------------------------------------------------------------
// Stereo tremolo testbench
// Drives stereo frames through the tremolo under a series of register
// settings, predicts each result with an independent fixed-point model of the
// raised-cosine LFO and the gain stage, and compares every result frame in
// order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module stereo_tremolo_tb;
  import stt_pkg::*;

  // Predicts the tremolo output for each accepted frame and checks results.
  class tremolo_scoreboard;
    bit                  enabled;
    logic [STEP_W-1:0]   step;
    logic [DEPTH_W-1:0]  depth;
    logic [CC_W-1:0]     chans;
    logic [PHASE_W-1:0]  phase;
    logic [TDATA_W-1:0]  expected_frames[$];
    int                  failures;

    function new();
      enabled  = 1'b0;
      step     = '0;
      depth    = '0;
      chans    = 2'd2;
      phase    = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ENABLE:        enabled = val[0];
        REG_PHASE_STEP:    step    = val[STEP_W-1:0];
        REG_DEPTH:         depth   = val[DEPTH_W-1:0];
        REG_CHANNEL_COUNT: chans   = val[CC_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned round_q16(longint unsigned x);
      return (x + 64'd32768) >> 16;
    endfunction

    // Raised-cosine LFO level in Q1.16 from the table index, via a folded
    // odd polynomial for the sine that is then squared.
    function longint unsigned lfo_level(logic [TABLE_W-1:0] k);
      longint unsigned half, u, t, t2, inner, mid, s;
      half  = 64'd1 << (TABLE_W - 1);
      u     = (k <= half) ? k : (2 * half) - k;
      t     = u << (17 - TABLE_W);
      t2    = round_q16(t * t);
      inner = COEF3 - round_q16(t2 * COEF5);
      mid   = COEF1 - round_q16(t2 * inner);
      s     = round_q16(t * mid);
      if (s > ONE_Q16) s = ONE_Q16;
      return round_q16(s * s);
    endfunction

    // Sample times Q1.15 gain, rounded half up and saturated.
    function logic [SAMPLE_W-1:0] scale_sample(logic signed [SAMPLE_W-1:0] x,
                                               longint unsigned gain);
      longint prod, q;
      prod = longint'(x) * longint'(gain) + 64'sd16384;
      q    = prod >>> 15;
      if (q > 64'sd32767) q = 64'sd32767;
      if (q < -64'sd32768) q = -64'sd32768;
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_frame(logic [TDATA_W-1:0] frame);
      logic [SAMPLE_W-1:0] left, right;
      longint unsigned     dep, gain;
      left  = frame[SAMPLE_W-1:0];
      right = frame[TDATA_W-1:SAMPLE_W];
      if (enabled) begin
        dep  = (depth > ONE_Q15) ? ONE_Q15 : depth;
        gain = ONE_Q15 - round_q16(dep * lfo_level(phase[PHASE_W-1 -: TABLE_W]));
        left = scale_sample(left, gain);
        if (chans >= 2) right = scale_sample(right, gain);
        phase = phase + step;
      end
      expected_frames.push_back({right, left});
    endfunction

    function void check_frame(logic [TDATA_W-1:0] got);
      logic [TDATA_W-1:0] want;
      if (expected_frames.size() == 0) begin
        if (failures < 10) $display("Unexpected result frame %h", got);
        failures++;
        return;
      end
      want = expected_frames.pop_front();
      if (want[SAMPLE_W-1:0] !== got[SAMPLE_W-1:0] ||
          want[TDATA_W-1:SAMPLE_W] !== got[TDATA_W-1:SAMPLE_W]) begin
        if (failures < 10)
          $display("Mismatch: left exp %h got %h, right exp %h got %h",
                   want[SAMPLE_W-1:0], got[SAMPLE_W-1:0],
                   want[TDATA_W-1:SAMPLE_W], got[TDATA_W-1:SAMPLE_W]);
        failures++;
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [TDATA_W-1:0]      in_tdata;   // [15:0] left_in, [31:16] right_in
  logic                    out_tvalid;
  logic                    out_tready;
  logic [TDATA_W-1:0]      out_tdata;  // [15:0] left_out, [31:16] right_out
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  tremolo_scoreboard sb = new();
  bit steady;

  stereo_tremolo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none during a steady stretch.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Called at a falling edge; returns at the falling edge after the write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offers one frame after a random gap and holds it until accepted.
  task automatic send_frame(logic [TDATA_W-1:0] frame);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = frame;
    do @(posedge clk); while (!in_tready);
    sb.note_frame(frame);
    @(negedge clk);
  endtask

  // Drops valid, waits for every result, then lets the block go idle.
  task automatic settle();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_all(bit en, logic [STEP_W-1:0] stp, logic [DEPTH_W-1:0] dep,
                           logic [CC_W-1:0] cc);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    write_reg(REG_ENABLE, {junk[30:1], en});
    write_reg(REG_PHASE_STEP, stp);
    write_reg(REG_DEPTH, {junk[30:16], dep});
    write_reg(REG_CHANNEL_COUNT, {junk[30:2], cc});
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] corners[4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    if ($urandom_range(0, 9) == 0) return corners[$urandom_range(0, 3)];
    return SAMPLE_W'($urandom);
  endfunction

  // Result side: random stalls, check on every accepted result.
  initial begin
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
        stall = pick_gap();
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_frame(out_tdata);
    end
  end

  // Main sequence: directed corners, then random settings and frames.
  initial begin
    logic [STEP_W-1:0]  stp;
    logic [DEPTH_W-1:0] dep;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_ENABLE;
    cfg_wdata = '0;
    steady    = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: disabled, frames pass through and the phase holds.
    send_frame({16'h8000, 16'h7FFF});
    send_frame({16'hFFFF, 16'h0000});
    settle();

    // Quarter-cycle steps land on the trough and the peak of the LFO.
    write_all(1'b1, 31'h4000_0000, ONE_Q15, 2'd2);
    send_frame({16'h8000, 16'h7FFF});
    send_frame({16'h7FFF, 16'h8000});
    send_frame({16'h7FFF, 16'h8000});
    settle();
    write_reg(REG_PHASE_STEP, 31'h0040_0000);
    send_frame({16'h0001, 16'hFFFF});
    send_frame({16'hFFFF, 16'h0001});
    send_frame({16'hAAAA, 16'h5555});
    settle();

    // Largest step wraps the phase; depth above full acts as full; count three.
    write_all(1'b1, 31'h7FFF_FFFF, 16'hFFFF, 2'd3);
    repeat (4) send_frame({16'h8000, 16'h7FFF});
    settle();

    // Mono, then channel count zero, which also acts as mono.
    write_all(1'b1, 31'h0123_4567, 16'd40000, 2'd1);
    repeat (3) send_frame({16'h7FFF, 16'h8000});
    settle();
    write_reg(REG_CHANNEL_COUNT, 2'd0);
    repeat (3) send_frame({16'h8000, 16'h7FFF});
    settle();

    // Disabled with a step set: no phase movement.
    write_reg(REG_ENABLE, 1'b0);
    send_frame({16'h1234, 16'hFEDC});
    send_frame({16'h8000, 16'h0000});
    settle();

    // Random settings, each followed by a run of random frames.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 5))
        0: stp = '0;
        1: stp = 31'h7FFF_FFFF;
        2: stp = STEP_W'($urandom_range(1, 1 << 22));
        default: stp = STEP_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: dep = '0;
        1: dep = ONE_Q15;
        2: dep = 16'hFFFF;
        3: dep = DEPTH_W'($urandom_range(32769, 65535));
        default: dep = DEPTH_W'($urandom_range(0, 32768));
      endcase
      write_all($urandom_range(0, 4) != 0, stp, dep, CC_W'($urandom_range(0, 3)));
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100; i++) send_frame({pick_sample(), pick_sample()});
      settle();
      steady = 1'b0;
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
